// ----- src/ptts_pkg.sv -----
// Shared types and constants of the periodic task tick scheduler.
`timescale 1ns / 1ps
package ptts_pkg;

	localparam int OP_W     = 2;
	localparam int HANDLE_W = 16;
	localparam int FIELD_W  = 16;
	localparam int SLOT_W   = 4;
	localparam int KIND_W   = 2;
	localparam int PEND_W   = 8;

	localparam logic [OP_W-1:0] OP_TICK     = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
	localparam logic [OP_W-1:0] OP_DEL      = 2'd2;
	localparam logic [OP_W-1:0] OP_DISPATCH = 2'd3;

	localparam logic [KIND_W-1:0] KIND_ADD_ACK = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DUE     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_IDLE    = 2'd2;

	localparam logic [PEND_W-1:0] PEND_MAX = 8'hFF;

	localparam int MAX_RESULTS = 16;
	localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [SLOT_W-1:0]   slot_number;
		logic [HANDLE_W-1:0] due_handle;
		logic                table_full;
		logic                last;
	} rsp_t;

	typedef struct packed {
		logic set;
		logic clr;
	} vld_op_t;

	typedef struct packed {
		logic emit;
		logic free_slot;
	} upd_flags_t;

endpackage

// ----- src/ptts_if.sv -----
// Command and response channel interfaces of the scheduler.
`timescale 1ns / 1ps
interface ptts_cmd_if;
	logic                              valid;
	logic                              ready;
	logic [ptts_pkg::OP_W-1:0]         op;
	logic [ptts_pkg::HANDLE_W-1:0]     task_handle;
	logic [ptts_pkg::FIELD_W-1:0]      first_delay;
	logic [ptts_pkg::FIELD_W-1:0]      run_period;
	logic [ptts_pkg::SLOT_W-1:0]       slot_index;

	modport source (output valid, op, task_handle, first_delay, run_period, slot_index,
		input ready);
	modport sink (input valid, op, task_handle, first_delay, run_period, slot_index,
		output ready);
endinterface

interface ptts_rsp_if;
	logic                              valid;
	logic                              ready;
	logic [ptts_pkg::KIND_W-1:0]       kind;
	logic [ptts_pkg::SLOT_W-1:0]       slot_number;
	logic [ptts_pkg::HANDLE_W-1:0]     due_handle;
	logic                              table_full;
	logic                              last;

	modport source (output valid, kind, slot_number, due_handle, table_full, last,
		input ready);
	modport sink (input valid, kind, slot_number, due_handle, table_full, last,
		output ready);
endinterface

// ----- src/periodic_task_tick_scheduler.sv -----
// Top level of the periodic task tick scheduler: sequencer, result holding and output register.
// One command at a time. A delete completes in the idle state. An add walks the valid flags one
// slot a cycle up to the first free slot, where it waits while the output register is busy.
// A tick or a dispatch scans the slots in order; a dispatch stops early after 16 reported slots
// and stalls while the response side holds ready low. The scan is paced by the slot table,
// whose single read port delivers one slot per cycle, but for those stalls, to the shared
// update unit. Results pass through an output register, so the next command is taken while the
// last result still waits. A full table answers an add with table_full set and stores nothing.
`timescale 1ns / 1ps
module periodic_task_tick_scheduler #(
	parameter int TASK_SLOTS = 16,
	parameter int TIME_BITS  = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	ptts_cmd_if.sink        cmd,
	ptts_rsp_if.source      rsp
);
	import ptts_pkg::*;

	localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
	localparam int CNT_W = $clog2(TASK_SLOTS + 1);
	localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(TASK_SLOTS - 1);
	localparam logic [RES_CNT_W-1:0] LAST_RES = RES_CNT_W'(MAX_RESULTS - 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_ADD   = 2'd1;
	localparam logic [1:0] S_SCAN  = 2'd2;
	localparam logic [1:0] S_FLUSH = 2'd3;

	logic [1:0]           state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [RES_CNT_W-1:0] res_cnt_q;
	logic                 disp_q;
	logic [HANDLE_W-1:0]  add_handle_q;
	logic [TIME_BITS-1:0] add_delay_q;
	logic [TIME_BITS-1:0] add_period_q;
	logic                 held_valid_q;
	logic [SLOT_W-1:0]    held_slot_q;
	logic [HANDLE_W-1:0]  held_handle_q;
	logic                 out_valid_q;
	rsp_t                 out_q;

	logic                 acc;
	logic                 out_free;
	logic [IDX_W-1:0]     cur_idx;
	logic                 slot_vld;
	logic                 last_slot;
	logic                 scan_stall;
	logic                 scan_step;
	logic                 scan_done;
	logic                 push;
	rsp_t                 push_data;

	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [HANDLE_W-1:0]  wr_handle;
	logic [TIME_BITS-1:0] wr_delay;
	logic [TIME_BITS-1:0] wr_period;
	logic [PEND_W-1:0]    wr_pending;
	logic                 rd_en;
	logic [IDX_W-1:0]     rd_addr;
	logic [HANDLE_W-1:0]  rd_handle;
	logic [TIME_BITS-1:0] rd_delay;
	logic [TIME_BITS-1:0] rd_period;
	logic [PEND_W-1:0]    rd_pending;
	vld_op_t              vld_op;
	logic [IDX_W-1:0]     vld_addr;
	logic [TASK_SLOTS-1:0] valid;

	logic [TIME_BITS-1:0] new_delay;
	logic [PEND_W-1:0]    new_pending;
	upd_flags_t           flags;

	ptts_table #(
		.TASK_SLOTS (TASK_SLOTS),
		.TIME_BITS  (TIME_BITS)
	) u_table (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_handle  (wr_handle),
		.wr_delay   (wr_delay),
		.wr_period  (wr_period),
		.wr_pending (wr_pending),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_handle  (rd_handle),
		.rd_delay   (rd_delay),
		.rd_period  (rd_period),
		.rd_pending (rd_pending),
		.vld_op     (vld_op),
		.vld_addr   (vld_addr),
		.valid      (valid)
	);

	ptts_update #(
		.TIME_BITS (TIME_BITS)
	) u_update (
		.is_dispatch (disp_q),
		.slot_valid  (slot_vld),
		.delay       (rd_delay),
		.period      (rd_period),
		.pending     (rd_pending),
		.new_delay   (new_delay),
		.new_pending (new_pending),
		.flags       (flags)
	);

	assign acc        = cmd.valid && cmd.ready;
	assign out_free   = !out_valid_q || rsp.ready;
	assign cur_idx    = cnt_q[IDX_W-1:0];
	assign slot_vld   = valid[cur_idx];
	assign last_slot  = (cnt_q == LAST_SLOT);
	assign scan_stall = (state_q == S_SCAN) && flags.emit && held_valid_q && !out_free;
	assign scan_step  = (state_q == S_SCAN) && !scan_stall;
	assign scan_done  = last_slot || (disp_q && flags.emit && res_cnt_q == LAST_RES);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		case (state_q)
			S_IDLE: begin
				rd_en = acc && (cmd.op == OP_TICK || cmd.op == OP_DISPATCH);
			end
			S_SCAN: begin
				if (scan_step) begin
					rd_en   = !last_slot;
					rd_addr = IDX_W'(cnt_q + CNT_W'(1));
				end else begin
					rd_en   = 1'b1;
					rd_addr = cur_idx;
				end
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = cur_idx;
		wr_handle  = rd_handle;
		wr_delay   = new_delay;
		wr_period  = rd_period;
		wr_pending = new_pending;
		vld_op     = '0;
		vld_addr   = cur_idx;
		push       = 1'b0;
		push_data  = '0;
		case (state_q)
			S_IDLE: begin
				if (acc && cmd.op == OP_DEL && 32'(cmd.slot_index) < 32'(TASK_SLOTS)) begin
					vld_op.clr = 1'b1;
					vld_addr   = IDX_W'(cmd.slot_index);
				end
			end
			S_ADD: begin
				if (out_free && !slot_vld) begin
					wr_en      = 1'b1;
					wr_handle  = add_handle_q;
					wr_delay   = add_delay_q;
					wr_period  = add_period_q;
					wr_pending = '0;
					vld_op.set = 1'b1;
					push       = 1'b1;
					push_data.kind        = KIND_ADD_ACK;
					push_data.slot_number = SLOT_W'(cur_idx);
					push_data.last        = 1'b1;
				end else if (out_free && last_slot) begin
					push       = 1'b1;
					push_data.kind       = KIND_ADD_ACK;
					push_data.table_full = 1'b1;
					push_data.last       = 1'b1;
				end
			end
			S_SCAN: begin
				if (scan_step) begin
					wr_en      = 1'b1;
					vld_op.clr = flags.free_slot;
					if (flags.emit && held_valid_q) begin
						push = 1'b1;
						push_data.kind        = KIND_DUE;
						push_data.slot_number = held_slot_q;
						push_data.due_handle  = held_handle_q;
					end
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					push           = 1'b1;
					push_data.last = 1'b1;
					if (held_valid_q) begin
						push_data.kind        = KIND_DUE;
						push_data.slot_number = held_slot_q;
						push_data.due_handle  = held_handle_q;
					end else begin
						push_data.kind = KIND_IDLE;
					end
				end
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			res_cnt_q    <= '0;
			disp_q       <= 1'b0;
			held_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						cnt_q     <= '0;
						res_cnt_q <= '0;
						disp_q    <= (cmd.op == OP_DISPATCH);
						if (cmd.op == OP_ADD) begin
							state_q <= S_ADD;
						end else if (cmd.op == OP_TICK || cmd.op == OP_DISPATCH) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_ADD: begin
					if (push) begin
						state_q <= S_IDLE;
					end else if (slot_vld && !last_slot) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_SCAN: begin
					if (scan_step) begin
						cnt_q <= cnt_q + CNT_W'(1);
						if (flags.emit) begin
							res_cnt_q    <= res_cnt_q + RES_CNT_W'(1);
							held_valid_q <= 1'b1;
						end
						if (scan_done) begin
							state_q <= disp_q ? S_FLUSH : S_IDLE;
						end
					end
				end
				S_FLUSH: begin
					if (push) begin
						held_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && cmd.op == OP_ADD) begin
			add_handle_q <= cmd.task_handle;
			add_delay_q  <= TIME_BITS'(cmd.first_delay);
			add_period_q <= TIME_BITS'(cmd.run_period);
		end
		if (scan_step && flags.emit) begin
			held_slot_q   <= SLOT_W'(cur_idx);
			held_handle_q <= rd_handle;
		end
		if (push) begin
			out_q <= push_data;
		end
	end

	assign cmd.ready       = (state_q == S_IDLE);
	assign rsp.valid       = out_valid_q;
	assign rsp.kind        = out_q.kind;
	assign rsp.slot_number = out_q.slot_number;
	assign rsp.due_handle  = out_q.due_handle;
	assign rsp.table_full  = out_q.table_full;
	assign rsp.last        = out_q.last;

endmodule

// ----- src/ptts_table.sv -----
// Slot table: valid flags in flip-flops, slot fields in a one-write one-read memory.
`timescale 1ns / 1ps
module ptts_table #(
	parameter int TASK_SLOTS = 16,
	parameter int TIME_BITS  = 16,
	localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [IDX_W-1:0]                  wr_addr,
	input  logic [ptts_pkg::HANDLE_W-1:0]     wr_handle,
	input  logic [TIME_BITS-1:0]              wr_delay,
	input  logic [TIME_BITS-1:0]              wr_period,
	input  logic [ptts_pkg::PEND_W-1:0]       wr_pending,
	input  logic                              rd_en,
	input  logic [IDX_W-1:0]                  rd_addr,
	output logic [ptts_pkg::HANDLE_W-1:0]     rd_handle,
	output logic [TIME_BITS-1:0]              rd_delay,
	output logic [TIME_BITS-1:0]              rd_period,
	output logic [ptts_pkg::PEND_W-1:0]       rd_pending,
	input  ptts_pkg::vld_op_t                 vld_op,
	input  logic [IDX_W-1:0]                  vld_addr,
	output logic [TASK_SLOTS-1:0]             valid
);
	import ptts_pkg::*;

	logic [HANDLE_W-1:0]  handle_mem  [TASK_SLOTS];
	logic [TIME_BITS-1:0] delay_mem   [TASK_SLOTS];
	logic [TIME_BITS-1:0] period_mem  [TASK_SLOTS];
	logic [PEND_W-1:0]    pending_mem [TASK_SLOTS];
	logic [TASK_SLOTS-1:0] valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			handle_mem[wr_addr]  <= wr_handle;
			delay_mem[wr_addr]   <= wr_delay;
			period_mem[wr_addr]  <= wr_period;
			pending_mem[wr_addr] <= wr_pending;
		end
		if (rd_en) begin
			rd_handle  <= handle_mem[rd_addr];
			rd_delay   <= delay_mem[rd_addr];
			rd_period  <= period_mem[rd_addr];
			rd_pending <= pending_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (vld_op.set) begin
			valid_q[vld_addr] <= 1'b1;
		end else if (vld_op.clr) begin
			valid_q[vld_addr] <= 1'b0;
		end
	end

	assign valid = valid_q;

endmodule

// ----- src/ptts_update.sv -----
// Shared slot update unit: one slot's tick countdown or dispatch step.
`timescale 1ns / 1ps
module ptts_update #(
	parameter int TIME_BITS = 16
) (
	input  logic                          is_dispatch,
	input  logic                          slot_valid,
	input  logic [TIME_BITS-1:0]          delay,
	input  logic [TIME_BITS-1:0]          period,
	input  logic [ptts_pkg::PEND_W-1:0]   pending,
	output logic [TIME_BITS-1:0]          new_delay,
	output logic [ptts_pkg::PEND_W-1:0]   new_pending,
	output ptts_pkg::upd_flags_t          flags
);
	import ptts_pkg::*;

	always_comb begin
		new_delay   = delay;
		new_pending = pending;
		flags       = '0;
		if (is_dispatch) begin
			if (slot_valid && pending != '0) begin
				flags.emit      = 1'b1;
				flags.free_slot = (period == '0);
				new_pending     = pending - PEND_W'(1);
			end
		end else if (slot_valid) begin
			if (delay != '0) begin
				new_delay = delay - TIME_BITS'(1);
			end else begin
				if (pending != PEND_MAX) begin
					new_pending = pending + PEND_W'(1);
				end
				if (period != '0) begin
					new_delay = period;
				end
			end
		end
	end

endmodule

// ----- src/ptts_checker.sv -----
// Port-level assertions of the scheduler and their binding to the top level.
`timescale 1ns / 1ps
module ptts_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            cmd_valid,
	input logic                            cmd_ready,
	input logic [ptts_pkg::OP_W-1:0]       cmd_op,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [ptts_pkg::KIND_W-1:0]     rsp_kind,
	input logic [ptts_pkg::HANDLE_W-1:0]   rsp_due_handle,
	input logic                            rsp_table_full,
	input logic                            rsp_last
);
	import ptts_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_due_handle))
		else $error("response transaction changed while stalled");

	a_full_is_add: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_table_full |-> rsp_kind == KIND_ADD_ACK && rsp_last)
		else $error("table_full outside a final add acknowledge");

	a_idle_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind != KIND_DUE |-> rsp_last && rsp_due_handle == '0)
		else $error("non-dispatch result not final or carries a handle");

	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_op != OP_DEL |=> !cmd_ready)
		else $error("command taken while previous transaction still in progress");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.cmd_op         (cmd.op),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_kind       (rsp.kind),
	.rsp_due_handle (rsp.due_handle),
	.rsp_table_full (rsp.table_full),
	.rsp_last       (rsp.last)
);

// ----- verif/periodic_task_tick_scheduler_tb.sv -----
// Self-checking testbench of the periodic task tick scheduler: directed, pressure and random tests.
`timescale 1ns / 1ps
module periodic_task_tick_scheduler_tb;
	import ptts_pkg::*;

	localparam int TASK_SLOTS = 16;
	localparam int TIME_BITS  = 16;
	localparam int SETTLE_GAP = TASK_SLOTS + 6;
	localparam int PRINT_MAX  = 40;

	logic clk;
	logic arst_n;

	ptts_cmd_if cmd ();
	ptts_rsp_if rsp ();

	periodic_task_tick_scheduler #(
		.TASK_SLOTS (TASK_SLOTS),
		.TIME_BITS  (TIME_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rsp    (rsp)
	);

	bit                  slot_used   [TASK_SLOTS];
	logic [HANDLE_W-1:0] slot_owner  [TASK_SLOTS];
	logic [FIELD_W-1:0]  slot_wait   [TASK_SLOTS];
	logic [FIELD_W-1:0]  slot_reload [TASK_SLOTS];
	logic [PEND_W-1:0]   slot_runs   [TASK_SLOTS];
	rsp_t                due_rsps[$];

	rsp_t seen_rsp;
	rsp_t want_rsp;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   stall_cycles;
	int   err_count;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	initial begin
		#4_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= PRINT_MAX) begin
			$display("ERROR at %0t ns: %s", $time, msg);
		end
	endtask

	function automatic rsp_t make_rsp(input logic [KIND_W-1:0] kind,
		input logic [SLOT_W-1:0] slot, input logic [HANDLE_W-1:0] handle,
		input logic full, input logic is_last);
		rsp_t r;
		r.kind        = kind;
		r.slot_number = slot;
		r.due_handle  = handle;
		r.table_full  = full;
		r.last        = is_last;
		return r;
	endfunction

	function automatic void clear_slot(input int s);
		slot_used[s]   = 1'b0;
		slot_owner[s]  = '0;
		slot_wait[s]   = '0;
		slot_reload[s] = '0;
		slot_runs[s]   = '0;
	endfunction

	// Apply one accepted transaction to the slot table and queue the responses it causes.
	function automatic void advance_slot_table(input logic [OP_W-1:0] op,
		input logic [HANDLE_W-1:0] handle, input logic [FIELD_W-1:0] delay,
		input logic [FIELD_W-1:0] period, input logic [SLOT_W-1:0] index);
		int   free_slot;
		int   n;
		rsp_t tail;
		free_slot = -1;
		n = 0;
		case (op)
			OP_TICK: begin
				for (int s = 0; s < TASK_SLOTS; s++) begin
					if (slot_used[s]) begin
						if (slot_wait[s] != '0) begin
							slot_wait[s] = slot_wait[s] - FIELD_W'(1);
						end else begin
							if (slot_runs[s] != PEND_MAX)
								slot_runs[s] = slot_runs[s] + PEND_W'(1);
							if (slot_reload[s] != '0)
								slot_wait[s] = slot_reload[s];
						end
					end
				end
			end
			OP_ADD: begin
				for (int s = 0; s < TASK_SLOTS; s++) begin
					if (!slot_used[s] && free_slot < 0)
						free_slot = s;
				end
				if (free_slot < 0) begin
					due_rsps.push_back(make_rsp(KIND_ADD_ACK, '0, '0, 1'b1, 1'b1));
				end else begin
					slot_used[free_slot]   = 1'b1;
					slot_owner[free_slot]  = handle;
					slot_wait[free_slot]   = delay;
					slot_reload[free_slot] = period;
					slot_runs[free_slot]   = '0;
					due_rsps.push_back(make_rsp(KIND_ADD_ACK, SLOT_W'(free_slot), '0, 1'b0,
						1'b1));
				end
			end
			OP_DEL: begin
				if (int'(index) < TASK_SLOTS)
					clear_slot(int'(index));
			end
			default: begin
				for (int s = 0; s < TASK_SLOTS; s++) begin
					if (n < MAX_RESULTS && slot_runs[s] != '0) begin
						due_rsps.push_back(make_rsp(KIND_DUE, SLOT_W'(s), slot_owner[s], 1'b0,
							1'b0));
						n++;
						slot_runs[s] = slot_runs[s] - PEND_W'(1);
						if (slot_reload[s] == '0)
							clear_slot(s);
					end
				end
				if (n == 0) begin
					due_rsps.push_back(make_rsp(KIND_IDLE, '0, '0, 1'b0, 1'b1));
				end else begin
					tail = due_rsps.pop_back();
					tail.last = 1'b1;
					due_rsps.push_back(tail);
				end
			end
		endcase
	endfunction

	task automatic send_cmd(input logic [OP_W-1:0] op, input logic [HANDLE_W-1:0] handle,
		input logic [FIELD_W-1:0] delay, input logic [FIELD_W-1:0] period,
		input logic [SLOT_W-1:0] index);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd.valid <= 1'b0;
			@(posedge clk);
		end
		cmd.valid       <= 1'b1;
		cmd.op          <= op;
		cmd.task_handle <= handle;
		cmd.first_delay <= delay;
		cmd.run_period  <= period;
		cmd.slot_index  <= index;
		do
			@(posedge clk);
		while (!cmd.ready);
		advance_slot_table(op, handle, delay, period, index);
	endtask

	task automatic send_tick();
		send_cmd(OP_TICK, HANDLE_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
			SLOT_W'($urandom));
	endtask

	task automatic send_add(input logic [HANDLE_W-1:0] handle, input logic [FIELD_W-1:0] delay,
		input logic [FIELD_W-1:0] period);
		send_cmd(OP_ADD, handle, delay, period, SLOT_W'($urandom));
	endtask

	task automatic send_delete(input logic [SLOT_W-1:0] index);
		send_cmd(OP_DEL, HANDLE_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom), index);
	endtask

	task automatic send_dispatch();
		send_cmd(OP_DISPATCH, HANDLE_W'($urandom), FIELD_W'($urandom), FIELD_W'($urandom),
			SLOT_W'($urandom));
	endtask

	task automatic wait_drained();
		cmd.valid <= 1'b0;
		while (due_rsps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_GAP) @(posedge clk);
	endtask

	function automatic logic [FIELD_W-1:0] pick_ticks();
		if ($urandom_range(7) == 0)
			return FIELD_W'($urandom);
		return FIELD_W'($urandom_range(4));
	endfunction

	// Receiver: random back-pressure, or a counted hold-off when one is requested.
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_cycles > 0) begin
				rsp.ready <= 1'b0;
				stall_cycles--;
			end else begin
				rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			seen_rsp = make_rsp(rsp.kind, rsp.slot_number, rsp.due_handle, rsp.table_full,
				rsp.last);
			if (due_rsps.size() == 0) begin
				report_mismatch($sformatf("unexpected response kind %0d slot %0d handle %h",
					seen_rsp.kind, seen_rsp.slot_number, seen_rsp.due_handle));
			end else begin
				want_rsp = due_rsps.pop_front();
				if (seen_rsp.kind !== want_rsp.kind)
					report_mismatch($sformatf("kind %0d, wanted %0d", seen_rsp.kind,
						want_rsp.kind));
				if (seen_rsp.slot_number !== want_rsp.slot_number)
					report_mismatch($sformatf("slot_number %0d, wanted %0d",
						seen_rsp.slot_number, want_rsp.slot_number));
				if (seen_rsp.due_handle !== want_rsp.due_handle)
					report_mismatch($sformatf("due_handle %h, wanted %h", seen_rsp.due_handle,
						want_rsp.due_handle));
				if (seen_rsp.table_full !== want_rsp.table_full)
					report_mismatch($sformatf("table_full %b, wanted %b", seen_rsp.table_full,
						want_rsp.table_full));
				if (seen_rsp.last !== want_rsp.last)
					report_mismatch($sformatf("last %b, wanted %b", seen_rsp.last,
						want_rsp.last));
			end
		end
	end

	task automatic test_field_extremes();
		send_dispatch();
		send_tick();
		send_add(16'hFFFF, 16'h0000, 16'h0000);
		send_add(16'h0000, 16'hFFFF, 16'hFFFF);
		send_add(16'hA5A5, 16'h0001, 16'h0001);
		send_add(16'h5A5A, 16'h0000, 16'hFFFF);
		send_dispatch();
		repeat (3) send_tick();
		send_dispatch();
		send_dispatch();
		send_add(16'h1234, 16'h0002, 16'h0000);
		send_delete(4'd1);
		send_delete(4'd15);
		send_delete(4'd2);
		send_delete(4'd3);
		send_delete(4'd0);
		send_dispatch();
	endtask

	task automatic test_table_full();
		for (int i = 0; i < TASK_SLOTS; i++)
			send_add(HANDLE_W'($urandom), '0, (i % 2 == 0) ? FIELD_W'(0) : FIELD_W'(i));
		send_add(HANDLE_W'($urandom), pick_ticks(), pick_ticks());
		send_tick();
		send_dispatch();
		send_add(HANDLE_W'($urandom), 16'h0001, 16'h0000);
		send_dispatch();
		for (int i = 0; i < TASK_SLOTS; i++)
			send_delete(SLOT_W'(i));
	endtask

	// Hold a one-shot slot at zero delay so that its run count saturates at 255.
	task automatic test_pending_saturation();
		for (int i = 0; i < TASK_SLOTS; i++)
			send_delete(SLOT_W'(i));
		send_add(16'hCAFE, 16'h0000, 16'h0000);
		repeat (256) send_tick();
		send_dispatch();
		send_dispatch();
	endtask

	task automatic test_receiver_stall();
		stall_cycles = 400;
		repeat (12) begin
			send_add(HANDLE_W'($urandom), '0, 16'h0001);
			send_tick();
			send_dispatch();
		end
		wait_drained();
	endtask

	task automatic test_random(input int count);
		int pick;
		int victim;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				send_tick();
			end else if (pick < 62) begin
				send_add(HANDLE_W'($urandom), pick_ticks(), pick_ticks());
			end else if (pick < 85) begin
				send_dispatch();
			end else begin
				victim = $urandom_range(TASK_SLOTS - 1);
				if ($urandom_range(3) != 0) begin
					for (int s = 0; s < TASK_SLOTS; s++) begin
						if (slot_used[(victim + s) % TASK_SLOTS] && !slot_used[victim])
							victim = (victim + s) % TASK_SLOTS;
					end
				end
				send_delete(SLOT_W'(victim));
			end
		end
	endtask

	initial begin
		arst_n          = 1'b0;
		err_count       = 0;
		stall_cycles    = 0;
		send_idle_pct   = 0;
		recv_idle_pct   = 0;
		cmd.valid       <= 1'b0;
		cmd.op          <= OP_TICK;
		cmd.task_handle <= '0;
		cmd.first_delay <= '0;
		cmd.run_period  <= '0;
		cmd.slot_index  <= '0;
		for (int s = 0; s < TASK_SLOTS; s++)
			clear_slot(s);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 10;
		recv_idle_pct = 72;
		test_field_extremes();
		test_table_full();
		test_random(40);
		test_receiver_stall();

		send_idle_pct = 72;
		recv_idle_pct = 10;
		test_random(40);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_pending_saturation();
		test_random(25);

		wait_drained();
		if (due_rsps.size() != 0)
			report_mismatch($sformatf("%0d responses never arrived", due_rsps.size()));
		if (err_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
